/* src/sibd_pkg.sv */
// shared types and constants for the signed integer to base digits core
package sibd_pkg;

  localparam int SYM_W       = 8;
  localparam int RADIX_W     = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [SYM_W-1:0]   MINUS_SIGN = 8'h2D;
  localparam logic [SYM_W-1:0]   PLUS_SIGN  = 8'h2B;
  localparam logic [RADIX_W-1:0] MIN_RADIX  = 5'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic load;
    logic next;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic nonzero;
  } div_stat_t;

  typedef struct packed {
    logic empty;
    logic one_left;
  } stk_stat_t;

endpackage

/* src/sibd_num_if.sv */
// input channel carrying one signed number per transaction
interface sibd_num_if #(
  parameter int NUMBER_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

/* src/sibd_sym_if.sv */
// output channel carrying one symbol byte per transaction
interface sibd_sym_if;
  logic                       valid;
  logic                       ready;
  logic [sibd_pkg::SYM_W-1:0] symbol;
  logic                       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

/* src/sibd_cfg_if.sv */
// configuration write channel
interface sibd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sibd_pkg::CFG_INDEX_W-1:0] index;
  logic [sibd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/sibd_alphabet.sv */
// alphabet check and digit to symbol lookup
module sibd_alphabet #(
  parameter int MAX_SYMBOLS = 16,
  parameter int DIGIT_W     = 4
) (
  input  logic [sibd_pkg::RADIX_W-1:0]    base_length,
  input  logic [sibd_pkg::CFG_DATA_W-1:0] symbols_low,
  input  logic [sibd_pkg::CFG_DATA_W-1:0] symbols_high,
  input  logic [DIGIT_W-1:0]              digit,
  output logic                            valid,
  output logic [sibd_pkg::SYM_W-1:0]      symbol
);

  localparam int ENTRIES = 2 ** DIGIT_W;

  logic [sibd_pkg::SYM_W-1:0] sym [ENTRIES];
  logic                       bad;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (k >= MAX_SYMBOLS) begin
        sym[k] = '0;
      end else if (k < 8) begin
        sym[k] = symbols_low[8 * (k & 7) +: 8];
      end else begin
        sym[k] = symbols_high[8 * (k & 7) +: 8];
      end
    end
  end

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (sibd_pkg::RADIX_W'(i) < base_length &&
          (sym[i] == sibd_pkg::MINUS_SIGN || sym[i] == sibd_pkg::PLUS_SIGN)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if (sibd_pkg::RADIX_W'(j) < base_length && sym[i] == sym[j]) begin
          bad = 1'b1;
        end
      end
    end
  end

  assign valid = !bad && base_length >= sibd_pkg::MIN_RADIX &&
                 base_length <= sibd_pkg::RADIX_W'(MAX_SYMBOLS);
  assign symbol = sym[digit];

endmodule

/* src/sibd_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
module sibd_divider #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sibd_pkg::div_cmd_t            cmd,
  input  logic [NUMBER_WIDTH-1:0]       dividend,
  input  logic [sibd_pkg::RADIX_W-1:0]  radix,
  output sibd_pkg::div_stat_t           stat,
  output logic [sibd_pkg::RADIX_W-1:0]  rem
);

  localparam int CNT_W = $clog2(NUMBER_WIDTH);

  logic [NUMBER_WIDTH-1:0]      q;
  logic [sibd_pkg::RADIX_W-1:0] r;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         done;
  logic                         nz;
  logic [sibd_pkg::RADIX_W-1:0] trial;
  logic                         qbit;
  logic [sibd_pkg::RADIX_W-1:0] r_next;

  assign trial  = {r[sibd_pkg::RADIX_W-2:0], q[NUMBER_WIDTH-1]};
  assign qbit   = trial >= radix;
  assign r_next = qbit ? trial - radix : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load || cmd.next) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.next) begin
      if (cmd.load) begin
        q <= dividend;
      end
      r   <= '0;
      nz  <= 1'b0;
      cnt <= CNT_W'(NUMBER_WIDTH - 1);
    end else if (busy) begin
      q   <= {q[NUMBER_WIDTH-2:0], qbit};
      r   <= r_next;
      nz  <= nz | qbit;
      cnt <= cnt - 1'b1;
    end
  end

  assign stat.busy    = busy;
  assign stat.done    = done;
  assign stat.nonzero = nz;
  assign rem          = r;

endmodule

/* src/sibd_digit_stack.sv */
// last-in first-out shift stack of digits
module sibd_digit_stack #(
  parameter int DEPTH   = 32,
  parameter int DIGIT_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  pop,
  input  logic [DIGIT_W-1:0]    din,
  output logic [DIGIT_W-1:0]    top,
  output sibd_pkg::stk_stat_t   stat
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DIGIT_W-1:0] st [DEPTH];
  logic [CNT_W-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      st[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        st[i] <= st[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        st[i] <= st[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= cnt + 1'b1;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign top           = st[0];
  assign stat.empty    = cnt == '0;
  assign stat.one_left = cnt == CNT_W'(1);

endmodule

/* src/signed_int_to_base_digits_core.sv */
// top level: renders signed numbers as symbol strings in a configured radix
//
// Each number takes a bit-serial division pass per digit, at most NUMBER_WIDTH digits,
// and one output symbol per digit, plus the minus sign for a negative number. The
// divider produces one quotient bit per cycle. A new number is accepted once the last
// symbol of the previous one sits in the output register. With an invalid alphabet
// (radix under 2 or above MAX_SYMBOLS, a repeated symbol, or a '+' or '-' in use) a
// number is taken and dropped with no output. The user must see that configuration
// is written only while idle; the block itself does not enforce it.
module signed_int_to_base_digits_core #(
  parameter int MAX_SYMBOLS  = 16,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  sibd_cfg_if.sink  cfg,
  sibd_num_if.sink  num,
  sibd_sym_if.source sym
);

  localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_DIG  = 2'd3;

  logic [sibd_pkg::RADIX_W-1:0]    base_length;
  logic [sibd_pkg::CFG_DATA_W-1:0] symbols_low;
  logic [sibd_pkg::CFG_DATA_W-1:0] symbols_high;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic                         neg;
  logic                         accept;
  logic [NUMBER_WIDTH-1:0]      mag;
  logic                         alpha_valid;
  logic [sibd_pkg::SYM_W-1:0]   digit_sym;
  sibd_pkg::div_cmd_t           div_cmd;
  sibd_pkg::div_stat_t          div_stat;
  logic [sibd_pkg::RADIX_W-1:0] div_rem;
  sibd_pkg::stk_stat_t          stk_stat;
  logic [DIGIT_W-1:0]           stk_top;
  logic                         push;
  logic                         pop;
  logic                         out_free;
  logic                         load_sign;
  logic                         load_dig;

  logic                         out_valid;
  logic [sibd_pkg::SYM_W-1:0]   out_symbol;
  logic                         out_last;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        sibd_pkg::REG_BASE_LENGTH:  base_length  <= cfg.data[sibd_pkg::RADIX_W-1:0];
        sibd_pkg::REG_SYMBOLS_LOW:  symbols_low  <= cfg.data;
        sibd_pkg::REG_SYMBOLS_HIGH: symbols_high <= cfg.data;
        default: ;
      endcase
    end
  end

  sibd_alphabet #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .DIGIT_W     (DIGIT_W)
  ) u_alphabet (
    .base_length  (base_length),
    .symbols_low  (symbols_low),
    .symbols_high (symbols_high),
    .digit        (stk_top),
    .valid        (alpha_valid),
    .symbol       (digit_sym)
  );

  assign num.ready = state == S_IDLE;
  assign accept    = num.valid && num.ready;
  assign mag       = num.number[NUMBER_WIDTH-1] ?
                     NUMBER_WIDTH'(~num.number + NUMBER_WIDTH'(1)) :
                     NUMBER_WIDTH'(num.number);

  assign div_cmd.load = accept && alpha_valid;
  assign div_cmd.next = state == S_DIV && div_stat.done && div_stat.nonzero;

  sibd_divider #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (mag),
    .radix    (base_length),
    .stat     (div_stat),
    .rem      (div_rem)
  );

  assign push = state == S_DIV && div_stat.done;

  sibd_digit_stack #(
    .DEPTH   (NUMBER_WIDTH),
    .DIGIT_W (DIGIT_W)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .din  (div_rem[DIGIT_W-1:0]),
    .top  (stk_top),
    .stat (stk_stat)
  );

  assign out_free  = !out_valid || sym.ready;
  assign load_sign = state == S_SIGN && out_free;
  assign load_dig  = state == S_DIG && out_free;
  assign pop       = load_dig;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (div_cmd.load) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done && !div_stat.nonzero) begin
          state_next = neg ? S_SIGN : S_DIG;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        if (out_free && stk_stat.one_left) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (div_cmd.load) begin
      neg <= num.number[NUMBER_WIDTH-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_sign || load_dig) begin
      out_valid <= 1'b1;
    end else if (sym.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      out_symbol <= sibd_pkg::MINUS_SIGN;
      out_last   <= 1'b0;
    end else if (load_dig) begin
      out_symbol <= digit_sym;
      out_last   <= stk_stat.one_left;
    end
  end

  assign sym.valid  = out_valid;
  assign sym.symbol = out_symbol;
  assign sym.last   = out_last;

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> stk_stat.empty)
    else $error("digit stack not empty while idle");

  a_no_emit_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !(state == S_SIGN || state == S_DIG))
    else $error("emission while divider busy");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (load_dig && stk_stat.one_left) |=> state == S_IDLE)
    else $error("final symbol did not end the transaction");

  a_invalid_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && !alpha_valid) |=> state == S_IDLE && !div_stat.busy)
    else $error("number with invalid alphabet was processed");

endmodule
